// ===== rtl/core/wtg_pkg.sv =====
// wavetable tone generator: shared constants, codes, divider request/response types
// and the half-sine table; no dependencies
`default_nettype none

package wtg_pkg;

  localparam int TABLE_SIZE   = 200;
  localparam int BASE_RATE_HZ = 125;
  localparam int SINE_ROM_LEN = 200;
  localparam int SINE_FULL    = 255;

  // divider widths: table size times base rate over a scaled frequency of up to 17 bits
  localparam int NUM_W   = 24;
  localparam int DEN_W   = 17;
  localparam int LEN_NUM = TABLE_SIZE * BASE_RATE_HZ;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_TONE = 2'd1,
    OP_STOP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SHAPE_SQUARE   = 2'd0,
    SHAPE_SAW      = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_SINE     = 2'd3
  } shape_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN_DIV,
    ST_SINE_IDX_DIV,
    ST_SINE_LOOKUP,
    ST_SAMPLE_DIV
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numerator;
    logic [DEN_W-1:0] denominator;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

  localparam logic [7:0] SINE_ROM [SINE_ROM_LEN] = '{
    8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,
    8'd7,   8'd9,   8'd10,  8'd12,  8'd14,  8'd15,  8'd17,  8'd20,  8'd22,  8'd24,
    8'd26,  8'd29,  8'd32,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,  8'd49,  8'd52,
    8'd56,  8'd59,  8'd62,  8'd66,  8'd69,  8'd73,  8'd77,  8'd80,  8'd84,  8'd88,
    8'd92,  8'd96,  8'd100, 8'd103, 8'd107, 8'd111, 8'd115, 8'd119, 8'd123, 8'd128,
    8'd128, 8'd132, 8'd136, 8'd140, 8'd144, 8'd148, 8'd152, 8'd155, 8'd159, 8'd163,
    8'd167, 8'd171, 8'd175, 8'd178, 8'd182, 8'd186, 8'd189, 8'd193, 8'd196, 8'd199,
    8'd203, 8'd206, 8'd209, 8'd212, 8'd215, 8'd218, 8'd221, 8'd223, 8'd226, 8'd229,
    8'd231, 8'd233, 8'd235, 8'd238, 8'd240, 8'd241, 8'd243, 8'd245, 8'd246, 8'd248,
    8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd253, 8'd253, 8'd252, 8'd251, 8'd250,
    8'd248, 8'd247, 8'd246, 8'd244, 8'd242, 8'd241, 8'd239, 8'd237, 8'd234, 8'd232,
    8'd230, 8'd227, 8'd225, 8'd222, 8'd219, 8'd217, 8'd214, 8'd211, 8'd208, 8'd204,
    8'd201, 8'd198, 8'd194, 8'd191, 8'd187, 8'd184, 8'd180, 8'd177, 8'd173, 8'd169,
    8'd165, 8'd161, 8'd157, 8'd153, 8'd150, 8'd146, 8'd142, 8'd138, 8'd134, 8'd130,
    8'd125, 8'd121, 8'd117, 8'd113, 8'd109, 8'd105, 8'd102, 8'd98,  8'd94,  8'd90,
    8'd86,  8'd82,  8'd78,  8'd75,  8'd71,  8'd68,  8'd64,  8'd61,  8'd57,  8'd54,
    8'd51,  8'd47,  8'd44,  8'd41,  8'd38,  8'd36,  8'd33,  8'd30,  8'd28,  8'd25,
    8'd23,  8'd21,  8'd18,  8'd16,  8'd14,  8'd13,  8'd11,  8'd9,   8'd8,   8'd7,
    8'd5,   8'd4,   8'd3,   8'd2,   8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0
  };

endpackage

`default_nettype wire

// ===== rtl/core/wtg_divider.sv =====
// wavetable tone generator: shared restoring divider, one quotient bit per cycle
// depends on wtg_pkg for widths and the request/response structs
`default_nettype none

module wtg_divider import wtg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign shifted = {rem, quo[NUM_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  // a zero divisor yields all ones in the quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.numerator;
      den <= req.denominator;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/core/wavetable_tone_generator_core.sv =====
// Wavetable tone generator. Each input transfer carries one operation (tick, tone request,
// stop or the unused code) and yields exactly one result transfer. A tick that falls on a
// sample, and a tone request that is taken, run through one shared 24-step divider: such
// an item occupies the block until its result is ready, and a sine sample divides twice
// (table position, then volume scaling through the table value). Other items are answered
// from the idle state. in_stall is high while an item is in work or while a finished
// result is held back by out_stall. Samples are computed on the fly from shape, volume,
// period length and index; waveform_select is sampled when a tone request is taken.
// depends on wtg_pkg and wtg_divider
`default_nettype none

module wavetable_tone_generator_core import wtg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] tone_hz,
  input  logic [7:0]  volume,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        duty_valid,
  output logic [9:0]  duty_level,
  output logic        accepted,
  output logic        playing
);

  localparam logic [17:0] BASE_18 = 18'(BASE_RATE_HZ);

  state_t      state, state_next;
  shape_t      waveform_select;
  logic [3:0]  tick_count, tick_count_next;
  logic [7:0]  sample_index, sample_index_next;
  shape_t      active_shape, active_shape_next;
  logic [7:0]  active_volume, active_volume_next;
  logic [7:0]  active_length, active_length_next;
  logic [3:0]  active_divisor, active_divisor_next;
  shape_t      pending_shape, pending_shape_next;
  logic [7:0]  pending_volume, pending_volume_next;
  logic [7:0]  pending_length, pending_length_next;
  logic [3:0]  pending_divisor, pending_divisor_next;
  logic        update_pending, update_pending_next;
  logic        is_playing, is_playing_next;
  logic        stop_pending, stop_pending_next;
  logic [7:0]  rom_value, rom_value_next;
  logic        out_valid_next;
  logic        duty_valid_next;
  logic [9:0]  duty_level_next;
  logic        accepted_next;
  logic        playing_next;

  logic        in_accept;
  logic        res_load;
  logic        res_valid;
  logic [9:0]  res_level;
  logic        res_accepted;
  logic [3:0]  tick_inc;
  logic [7:0]  half;
  logic [7:0]  len_minus_idx;
  logic        tri_rising;
  logic [7:0]  idx_inc;
  logic        wrap;
  logic [7:0]  mul_a, mul_b;
  logic [15:0] mul_p;
  logic [17:0] hz_x4, hz_x2, hz_x1;
  logic [3:0]  div_choice;
  logic [16:0] scaled;
  logic [7:0]  len_clamped;
  logic [7:0]  sine_idx;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  wtg_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign tick_inc      = tick_count + 4'd1;
  assign half          = {1'b0, active_length[7:1]};
  assign len_minus_idx = active_length - sample_index;
  assign tri_rising    = sample_index <= half;
  assign idx_inc       = sample_index + 8'd1;
  assign wrap          = idx_inc == (active_length - 8'd1);

  // clock divisor and scaled frequency for a tone request
  assign hz_x4 = {tone_hz, 2'b00};
  assign hz_x2 = {1'b0, tone_hz, 1'b0};
  assign hz_x1 = {2'b00, tone_hz};

  always_comb begin
    if (hz_x4 <= BASE_18) begin
      div_choice = 4'd8;
      scaled     = {tone_hz[13:0], 3'b000};
    end else if (hz_x2 <= BASE_18) begin
      div_choice = 4'd4;
      scaled     = {tone_hz[14:0], 2'b00};
    end else if (hz_x1 <= BASE_18) begin
      div_choice = 4'd2;
      scaled     = {tone_hz, 1'b0};
    end else begin
      div_choice = 4'd1;
      scaled     = {1'b0, tone_hz};
    end
  end

  always_comb begin
    if (div_rsp.quotient > NUM_W'(TABLE_SIZE)) begin
      len_clamped = 8'(TABLE_SIZE);
    end else if (div_rsp.quotient < NUM_W'(2)) begin
      len_clamped = 8'd2;
    end else begin
      len_clamped = div_rsp.quotient[7:0];
    end
  end

  assign sine_idx = (div_rsp.quotient >= NUM_W'(SINE_ROM_LEN)) ?
                    8'(SINE_ROM_LEN - 1) : div_rsp.quotient[7:0];

  // the one multiplier, shared by sample numerators and sine scaling
  always_comb begin
    if (state == ST_SINE_LOOKUP) begin
      mul_a = rom_value;
      mul_b = active_volume;
    end else if (active_shape == SHAPE_SINE) begin
      mul_a = 8'(SINE_ROM_LEN);
      mul_b = sample_index;
    end else if (active_shape == SHAPE_TRIANGLE && !tri_rising) begin
      mul_a = active_volume;
      mul_b = len_minus_idx;
    end else begin
      mul_a = active_volume;
      mul_b = sample_index;
    end
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_next           = state;
    tick_count_next      = tick_count;
    sample_index_next    = sample_index;
    active_shape_next    = active_shape;
    active_volume_next   = active_volume;
    active_length_next   = active_length;
    active_divisor_next  = active_divisor;
    pending_shape_next   = pending_shape;
    pending_volume_next  = pending_volume;
    pending_length_next  = pending_length;
    pending_divisor_next = pending_divisor;
    update_pending_next  = update_pending;
    is_playing_next      = is_playing;
    stop_pending_next    = stop_pending;
    rom_value_next       = rom_value;
    div_req.start        = 1'b0;
    div_req.numerator    = '0;
    div_req.denominator  = DEN_W'(1);
    res_load             = 1'b0;
    res_valid            = 1'b0;
    res_level            = '0;
    res_accepted         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (op_t'(operation))
            OP_TICK: begin
              if (is_playing && tick_inc == active_divisor) begin
                tick_count_next     = '0;
                div_req.start       = 1'b1;
                div_req.denominator = DEN_W'(active_length);
                state_next          = ST_SAMPLE_DIV;
                if (active_length == '0) begin
                  div_req.denominator = DEN_W'(1);
                end else begin
                  case (active_shape)
                    SHAPE_SQUARE: begin
                      div_req.denominator = DEN_W'(1);
                      div_req.numerator   = (sample_index < half) ?
                                            '0 : NUM_W'(active_volume);
                    end
                    SHAPE_SAW: begin
                      div_req.numerator = NUM_W'(mul_p);
                    end
                    SHAPE_TRIANGLE: begin
                      if (!tri_rising && sample_index >= active_length) begin
                        div_req.numerator = '0;
                      end else begin
                        div_req.numerator = NUM_W'({mul_p, 1'b0});
                      end
                    end
                    default: begin
                      div_req.numerator = NUM_W'(mul_p);
                      state_next        = ST_SINE_IDX_DIV;
                    end
                  endcase
                end
              end else begin
                if (is_playing) begin
                  tick_count_next = tick_inc;
                end
                res_load = 1'b1;
              end
            end
            OP_TONE: begin
              if (!update_pending) begin
                div_req.start        = 1'b1;
                div_req.numerator    = NUM_W'(LEN_NUM);
                div_req.denominator  = scaled;
                pending_shape_next   = waveform_select;
                pending_volume_next  = volume;
                pending_divisor_next = div_choice;
                state_next           = ST_LEN_DIV;
              end else begin
                res_load = 1'b1;
              end
            end
            OP_STOP: begin
              stop_pending_next = 1'b1;
              res_load          = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      ST_LEN_DIV: begin
        if (div_rsp.done) begin
          pending_length_next = len_clamped;
          update_pending_next = 1'b1;
          res_accepted        = 1'b1;
          if (!is_playing) begin
            // start from idle: load the request at once and give a zero duty
            is_playing_next     = 1'b1;
            update_pending_next = 1'b0;
            active_shape_next   = pending_shape;
            active_volume_next  = pending_volume;
            active_divisor_next = pending_divisor;
            active_length_next  = len_clamped;
            sample_index_next   = '0;
            tick_count_next     = '0;
            res_valid           = 1'b1;
          end
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_SINE_IDX_DIV: begin
        if (div_rsp.done) begin
          rom_value_next = SINE_ROM[sine_idx];
          state_next     = ST_SINE_LOOKUP;
        end
      end

      ST_SINE_LOOKUP: begin
        div_req.start       = 1'b1;
        div_req.numerator   = NUM_W'(mul_p);
        div_req.denominator = DEN_W'(SINE_FULL);
        state_next          = ST_SAMPLE_DIV;
      end

      ST_SAMPLE_DIV: begin
        if (div_rsp.done) begin
          res_valid         = 1'b1;
          res_level         = {div_rsp.quotient[7:0], 2'b00};
          sample_index_next = wrap ? 8'd0 : idx_inc;
          // end of period: take up a waiting request, then a waiting stop
          if (wrap && update_pending) begin
            update_pending_next = 1'b0;
            active_shape_next   = pending_shape;
            active_volume_next  = pending_volume;
            active_length_next  = pending_length;
            active_divisor_next = pending_divisor;
            tick_count_next     = '0;
          end
          if (wrap && stop_pending) begin
            stop_pending_next = 1'b0;
            is_playing_next   = 1'b0;
          end
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next  = out_valid && out_stall;
    duty_valid_next = duty_valid;
    duty_level_next = duty_level;
    accepted_next   = accepted;
    playing_next    = playing;
    if (res_load) begin
      out_valid_next  = 1'b1;
      duty_valid_next = res_valid;
      duty_level_next = res_level;
      accepted_next   = res_accepted;
      playing_next    = is_playing_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      waveform_select <= SHAPE_SQUARE;
      tick_count      <= '0;
      sample_index    <= '0;
      active_shape    <= SHAPE_SQUARE;
      active_volume   <= '0;
      active_length   <= 8'd1;
      active_divisor  <= 4'd1;
      pending_shape   <= SHAPE_SQUARE;
      pending_volume  <= '0;
      pending_length  <= 8'd1;
      pending_divisor <= 4'd1;
      update_pending  <= 1'b0;
      is_playing      <= 1'b0;
      stop_pending    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      if (cfg_wr_en) begin
        waveform_select <= shape_t'(cfg_wr_data);
      end
      tick_count      <= tick_count_next;
      sample_index    <= sample_index_next;
      active_shape    <= active_shape_next;
      active_volume   <= active_volume_next;
      active_length   <= active_length_next;
      active_divisor  <= active_divisor_next;
      pending_shape   <= pending_shape_next;
      pending_volume  <= pending_volume_next;
      pending_length  <= pending_length_next;
      pending_divisor <= pending_divisor_next;
      update_pending  <= update_pending_next;
      is_playing      <= is_playing_next;
      stop_pending    <= stop_pending_next;
      out_valid       <= out_valid_next;
    end
  end

  // result register and sine table value
  always_ff @(posedge clk) begin
    rom_value  <= rom_value_next;
    duty_valid <= duty_valid_next;
    duty_level <= duty_level_next;
    accepted   <= accepted_next;
    playing    <= playing_next;
  end

endmodule

`default_nettype wire

// ===== tb/sv/wavetable_tone_generator_core_tb.sv =====
// testbench for wavetable_tone_generator_core: directed and random item streams, with an
// item-level predictor of the tone state and a queue of expected duty results
// depends on wtg_pkg and the core rtl
module wavetable_tone_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wtg_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES = 120;
  localparam int unsigned ITEMS_PER_SHAPE = 65;

  typedef struct packed {
    logic       duty_valid;
    logic [9:0] duty_level;
    logic       accepted;
    logic       playing;
  } duty_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_TICK;
  logic [15:0] tone_hz = 16'd0;
  logic [7:0]  volume = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        duty_valid;
  logic [9:0]  duty_level;
  logic        accepted;
  logic        playing;

  wavetable_tone_generator_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .tone_hz    (tone_hz),
    .volume     (volume),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .duty_valid (duty_valid),
    .duty_level (duty_level),
    .accepted   (accepted),
    .playing    (playing)
  );

  always #5 clk = ~clk;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned quiet_cycles = 0;

  duty_result_t expected_duty_q[$];

  // predicted tone state
  shape_t     waveform_reg = SHAPE_SQUARE;
  logic [3:0] tick_cnt = 4'd0;
  logic [7:0] sample_idx = 8'd0;
  shape_t     cur_shape = SHAPE_SQUARE;
  logic [7:0] cur_vol = 8'd0;
  logic [7:0] cur_len = 8'd1;
  logic [3:0] cur_div = 4'd1;
  shape_t     next_shape = SHAPE_SQUARE;
  logic [7:0] next_vol = 8'd0;
  logic [7:0] next_len = 8'd1;
  logic [3:0] next_div = 4'd1;
  logic       next_waiting = 1'b0;
  logic       tone_on = 1'b0;
  logic       stop_armed = 1'b0;

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  function automatic logic [7:0] sample_value(shape_t s, logic [7:0] v, logic [7:0] len,
                                               logic [7:0] i);
    int unsigned vv, ll, ii, half, pos;
    vv = v;
    ll = len;
    ii = i;
    half = ll / 2;
    case (s)
      SHAPE_SQUARE: return (ii < half) ? 8'd0 : v;
      SHAPE_SAW: return 8'((vv * ii) / ll);
      SHAPE_TRIANGLE: begin
        if (ii <= half) return 8'((2 * vv * ii) / ll);
        if (ii >= ll) return 8'd0;
        return 8'((2 * vv * (ll - ii)) / ll);
      end
      default: begin
        pos = (SINE_ROM_LEN * ii) / ll;
        if (pos >= SINE_ROM_LEN) pos = SINE_ROM_LEN - 1;
        return 8'((SINE_ROM[pos] * vv) / SINE_FULL);
      end
    endcase
  endfunction

  function automatic void load_next_tone();
    next_waiting = 1'b0;
    cur_shape = next_shape;
    cur_vol = next_vol;
    cur_len = next_len;
    cur_div = next_div;
    sample_idx = 8'd0;
    tick_cnt = 4'd0;
  endfunction

  function automatic duty_result_t predict_duty(logic [1:0] op, logic [15:0] hz,
                                                logic [7:0] vol);
    duty_result_t r;
    int unsigned hzv, divv, scaled, lenv;
    r = '0;
    case (op)
      OP_TICK: begin
        if (tone_on) begin
          tick_cnt = tick_cnt + 4'd1;
          if (tick_cnt == cur_div) begin
            tick_cnt = 4'd0;
            r.duty_valid = 1'b1;
            r.duty_level = {sample_value(cur_shape, cur_vol, cur_len, sample_idx), 2'b00};
            sample_idx = sample_idx + 8'd1;
            // end of period: wrap, take a waiting request, then honour a stop
            if (sample_idx == cur_len - 8'd1) begin
              sample_idx = 8'd0;
              if (next_waiting) load_next_tone();
              if (stop_armed) begin
                stop_armed = 1'b0;
                tone_on = 1'b0;
              end
            end
          end
        end
      end
      OP_TONE: begin
        if (!next_waiting) begin
          hzv = hz;
          if (4 * hzv <= BASE_RATE_HZ) divv = 8;
          else if (2 * hzv <= BASE_RATE_HZ) divv = 4;
          else if (hzv <= BASE_RATE_HZ) divv = 2;
          else divv = 1;
          scaled = hzv * divv;
          lenv = (scaled == 0) ? TABLE_SIZE : (TABLE_SIZE * BASE_RATE_HZ) / scaled;
          if (lenv > TABLE_SIZE) lenv = TABLE_SIZE;
          if (lenv < 2) lenv = 2;
          next_shape = waveform_reg;
          next_vol = vol;
          next_len = 8'(lenv);
          next_div = 4'(divv);
          next_waiting = 1'b1;
          r.accepted = 1'b1;
          if (!tone_on) begin
            tone_on = 1'b1;
            load_next_tone();
            r.duty_valid = 1'b1;
          end
        end
      end
      OP_STOP: stop_armed = 1'b1;
      default: ;
    endcase
    r.playing = tone_on;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("mismatch at result %0d: %s", result_count, msg);
  endtask

  // all handshake signals are stable at the falling edge; a transfer seen here
  // completes at the next rising edge
  always @(negedge clk) begin : monitor
    duty_result_t want;
    bit moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        expected_duty_q.push_back(predict_duty(operation, tone_hz, volume));
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_duty_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_duty_q.pop_front();
          if (duty_valid !== want.duty_valid)
            report_mismatch($sformatf("duty_valid %b, expected %b", duty_valid,
                                      want.duty_valid));
          if (duty_level !== want.duty_level)
            report_mismatch($sformatf("duty_level %0d, expected %0d", duty_level,
                                      want.duty_level));
          if (accepted !== want.accepted)
            report_mismatch($sformatf("accepted %b, expected %b", accepted, want.accepted));
          if (playing !== want.playing)
            report_mismatch($sformatf("playing %b, expected %b", playing, want.playing));
        end
        result_count++;
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [15:0] hz, input logic [7:0] vol);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    tone_hz <= hz;
    volume <= vol;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_duty_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_waveform(shape_t s);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    waveform_reg = s;
  endtask

  // stop the tone and tick until its period is over
  task automatic play_out_tone();
    if (tone_on) send_item(OP_STOP, 16'($urandom), 8'($urandom));
    while (tone_on) send_item(OP_TICK, 16'($urandom), 8'($urandom));
    wait_idle();
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 16'($urandom), 8'($urandom));
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [1:0] op;
    logic [15:0] hz;
    pick = $urandom_range(99);
    hz = 16'($urandom);
    if (pick < 76) op = OP_TICK;
    else if (pick < 94) op = OP_TONE;
    else if (pick < 98) op = OP_STOP;
    else op = OP_UNUSED;
    // mostly short periods so that requests and stops take effect often
    if (op == OP_TONE) begin
      pick = $urandom_range(99);
      if (pick < 70) hz = 16'($urandom_range(65535, 2000));
      else hz = 16'($urandom_range(1999, 1000));
    end
    send_item(op, hz, 8'($urandom));
  endtask

  task automatic test_idle_tick_and_stop();
    write_waveform(SHAPE_SQUARE);
    send_tick();
    send_item(OP_UNUSED, 16'hffff, 8'hff);
    send_item(OP_STOP, 16'h0000, 8'h00);
    // stop armed while idle: the next tone lasts one period
    send_item(OP_TONE, 16'hffff, 8'hff);
    send_tick();
    send_tick();
    play_out_tone();
  endtask

  task automatic test_pending_request();
    write_waveform(SHAPE_TRIANGLE);
    send_item(OP_TONE, 16'd125, 8'd255);
    send_item(OP_TONE, 16'd126, 8'd128);
    send_item(OP_TONE, 16'd62, 8'd1);
    repeat (4) send_tick();
    send_item(OP_UNUSED, 16'd0, 8'd0);
    play_out_tone();
  endtask

  // a zero-hertz tone has the longest period, far more ticks than this test sends, so this
  // test runs last and leaves the tone playing
  task automatic test_zero_frequency();
    write_waveform(SHAPE_SINE);
    send_item(OP_TONE, 16'd0, 8'd255);
    send_item(OP_TONE, 16'd31, 8'd0);
    repeat (40) send_tick();
    wait_idle();
  endtask

  task automatic test_length_clamp();
    write_waveform(SHAPE_SAW);
    send_item(OP_TONE, 16'd12501, 8'd255);
    send_item(OP_TONE, 16'd32, 8'd200);
    repeat (3) send_tick();
    play_out_tone();
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < 4; k++) begin
      write_waveform(shape_t'(k));
      repeat (ITEMS_PER_SHAPE) send_random_item();
      play_out_tone();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 65;
    test_idle_tick_and_stop();
    test_pending_request();
    test_length_clamp();
    test_random_traffic(37, 65);
    test_random_traffic(65, 37);
    test_random_traffic(0, 0);
    test_zero_frequency();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_duty_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
